// File: design/fbpa_pkg.sv
`timescale 1ns / 1ps

package fbpa_pkg;

	// Pool geometry.
	localparam int NUM_CHUNKS     = 256;
	localparam int MAX_CHUNK_SIZE = 65536;

	// Widths of indexes, links and item fields.
	localparam int IDX_W    = $clog2(NUM_CHUNKS);
	localparam int LINK_W   = IDX_W + 1;
	localparam int POOL_W   = 9;
	localparam int SIZE_W   = 17;
	localparam int REQ_W    = 16;
	localparam int OFFS_W   = 24;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;

	// A link value of NUM_CHUNKS marks the end of the free list.
	localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(NUM_CHUNKS);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_POOL_CHUNKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = 1'd1;

	// Register values after reset.
	localparam logic [POOL_W-1:0] POOL_CHUNKS_RST = 9'd256;
	localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST  = 17'd64;

	typedef enum logic {
		ACT_ALLOC   = 1'b0,
		ACT_RELEASE = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_EMPTY     = 2'd1,
		STAT_TOO_LARGE = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic               action;
		logic [REQ_W-1:0]   request_size;
		logic [OFFS_W-1:0]  free_offset;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [IDX_W-1:0]   chunk_index;
		logic [OFFS_W-1:0]  chunk_offset;
		logic               pool_empty;
	} rsp_t;

	// One access to the link memory per cycle, plus the rebuild request.
	typedef struct packed {
		logic               clear;
		logic               wr_en;
		logic [IDX_W-1:0]   addr;
		logic [LINK_W-1:0]  wr_data;
	} link_req_t;

endpackage

// File: design/fbpa_if.sv
`timescale 1ns / 1ps

// Request channel: one allocation or release per item.
interface fbpa_req_if import fbpa_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// Result channel: one result per request item.
interface fbpa_rsp_if import fbpa_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: design/fbpa_div.sv
`timescale 1ns / 1ps

// Restoring divider, two quotient bits per cycle.
module fbpa_div import fbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [OFFS_W-1:0] dividend,
	input  logic [SIZE_W-1:0] divisor,
	output logic              done,
	output logic [OFFS_W-1:0] quotient
);

	localparam int DIV_STEPS = OFFS_W / 2;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	logic [OFFS_W-1:0] quo_q;
	logic [SIZE_W-1:0] rem_q;
	logic [SIZE_W-1:0] div_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [SIZE_W:0]   r1, r1n, r2, r2n;
	logic              ge1, ge2;

	// Two dependent shift-and-subtract steps.
	always_comb begin
		r1  = {rem_q, quo_q[OFFS_W-1]};
		ge1 = (r1 >= {1'b0, div_q});
		r1n = ge1 ? (r1 - {1'b0, div_q}) : r1;
		r2  = {r1n[SIZE_W-1:0], quo_q[OFFS_W-2]};
		ge2 = (r2 >= {1'b0, div_q});
		r2n = ge2 ? (r2 - {1'b0, div_q}) : r2;
	end

	// Control: step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the dividend register fills with quotient bits.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[OFFS_W-3:0], ge1, ge2};
			rem_q <= r2n[SIZE_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: design/fbpa_link_ram.sv
`timescale 1ns / 1ps

// Free-list link memory with a registered read. Entries not written
// since the last rebuild read as the ascending chain.
module fbpa_link_ram import fbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [LINK_W-1:0] chunks,
	input  link_req_t         req,
	output logic [LINK_W-1:0] rd_link
);

	logic [LINK_W-1:0]     mem [NUM_CHUNKS];
	logic [NUM_CHUNKS-1:0] valid_q;
	logic [LINK_W-1:0]     rd_data_s1;
	logic                  rd_valid_s1;
	logic [IDX_W-1:0]      rd_addr_s1;
	logic [LINK_W-1:0]     chain_next;

	// Storage array and registered read.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.addr] <= req.wr_data;
		end
		rd_data_s1 <= mem[req.addr];
		rd_addr_s1 <= req.addr;
	end

	// Written-entry flags, all cleared at once by a rebuild.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[req.addr];
			if (req.clear) begin
				valid_q <= '0;
			end else if (req.wr_en) begin
				valid_q[req.addr] <= 1'b1;
			end
		end
	end

	// Value of an untouched entry: the next chunk, or none after the last.
	always_comb begin
		chain_next = {1'b0, rd_addr_s1} + 1'b1;
		if (chain_next >= chunks) begin
			chain_next = LINK_NONE;
		end
	end

	assign rd_link = rd_valid_s1 ? rd_data_s1 : chain_next;

endmodule

// File: design/fixed_block_pool_allocator_core.sv
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Each request item either allocates a
// chunk (popping the head of a linked free list) or releases one (its byte
// offset divided by the chunk size is pushed onto the list), and yields one
// result item with a status, the chunk index, its byte offset and whether
// the pool is now empty. Reset and any configuration write rebuild the list
// in ascending order at once, with no clearing pass, so a request may follow
// immediately. One item is worked on at a time: an allocation reads the link
// memory, then forms the index-by-size product into the output register; a
// release runs the radix-4 divider on the 24-bit offset, then writes the
// link memory and forms the product. The result sits in an output register,
// so the next item is taken while a result still waits to be collected.
module fixed_block_pool_allocator_core import fbpa_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	fbpa_req_if.sink              req,
	fbpa_rsp_if.source            rsp
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_LINK   = 4'b0010,
		S_DIV    = 4'b0100,
		S_RESULT = 4'b1000
	} state_t;

	state_t              state_q;
	logic [POOL_W-1:0]   pool_chunks_q;
	logic [SIZE_W-1:0]   chunk_size_q;
	logic [LINK_W-1:0]   free_head_q;
	status_t             status_q;
	logic [IDX_W-1:0]    idx_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic [LINK_W-1:0]   chunks;
	logic [SIZE_W-1:0]   size;
	logic                accept;
	logic                div_start;
	logic                div_done;
	logic [OFFS_W-1:0]   quotient;
	logic                q_in_range;
	logic [LINK_W-1:0]   rd_link;
	link_req_t           link_req;
	logic                rsp_load;
	logic [IDX_W+SIZE_W-1:0] product;

	// Register values clamped to their working ranges.
	always_comb begin
		if (pool_chunks_q == '0) begin
			chunks = LINK_W'(1);
		end else if (pool_chunks_q > POOL_W'(NUM_CHUNKS)) begin
			chunks = LINK_W'(NUM_CHUNKS);
		end else begin
			chunks = LINK_W'(pool_chunks_q);
		end
		if (chunk_size_q == '0) begin
			size = SIZE_W'(1);
		end else if (chunk_size_q > SIZE_W'(MAX_CHUNK_SIZE)) begin
			size = SIZE_W'(MAX_CHUNK_SIZE);
		end else begin
			size = chunk_size_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign div_start = accept && (req.data.action == ACT_RELEASE);

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (req.data.free_offset),
		.divisor  (size),
		.done     (div_done),
		.quotient (quotient)
	);

	assign q_in_range = (quotient < OFFS_W'(chunks));

	// One link access per cycle: read at the head while idle, write the
	// released chunk when the divider finishes.
	always_comb begin
		link_req.clear   = cfg_we;
		link_req.wr_en   = (state_q == S_DIV) && div_done && q_in_range;
		link_req.addr    = (state_q == S_DIV) ? quotient[IDX_W-1:0]
		                                       : free_head_q[IDX_W-1:0];
		link_req.wr_data = (free_head_q < chunks) ? free_head_q : LINK_NONE;
	end

	fbpa_link_ram u_link_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.chunks  (chunks),
		.req     (link_req),
		.rd_link (rd_link)
	);

	// Sequencer, free-list head and configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			pool_chunks_q <= POOL_CHUNKS_RST;
			chunk_size_q  <= CHUNK_SIZE_RST;
			free_head_q   <= '0;
			status_q      <= STAT_OK;
			idx_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_POOL_CHUNKS: pool_chunks_q <= cfg_data[POOL_W-1:0];
					REG_CHUNK_SIZE:  chunk_size_q  <= cfg_data[SIZE_W-1:0];
				endcase
				free_head_q <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.data.action == ACT_RELEASE) begin
							state_q <= S_DIV;
						end else begin
							idx_q   <= free_head_q[IDX_W-1:0];
							state_q <= S_LINK;
							if ({1'b0, req.data.request_size} >= size) begin
								status_q <= STAT_TOO_LARGE;
							end else if (free_head_q >= chunks) begin
								status_q <= STAT_EMPTY;
							end else begin
								status_q <= STAT_OK;
							end
						end
					end
				end
				S_LINK: begin
					if (status_q == STAT_OK) begin
						free_head_q <= rd_link;
					end
					state_q <= S_RESULT;
				end
				S_DIV: begin
					if (div_done) begin
						if (q_in_range) begin
							status_q    <= STAT_OK;
							idx_q       <= quotient[IDX_W-1:0];
							free_head_q <= {1'b0, quotient[IDX_W-1:0]};
						end else begin
							status_q <= STAT_RANGE;
						end
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Byte offset of the chunk, registered straight into the result.
	assign product  = {{SIZE_W{1'b0}}, idx_q} * {{IDX_W{1'b0}}, size};
	assign rsp_load = (state_q == S_RESULT) && (!rsp_valid_q || rsp.ready);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status       <= status_q;
			rsp_q.chunk_index  <= (status_q == STAT_OK) ? idx_q : '0;
			rsp_q.chunk_offset <= (status_q == STAT_OK) ? product[OFFS_W-1:0] : '0;
			rsp_q.pool_empty   <= (free_head_q >= chunks);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

endmodule

// File: design/fbpa_checker.sv
`timescale 1ns / 1ps

// Port-level checks on the allocator.
module fbpa_checker import fbpa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// A waiting result stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn while stalled");

	// A waiting result keeps its contents.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result changed while stalled");

	// One item at a time: no new item straight after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item taken while one is at work");

	// Failed requests report no chunk.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status != STAT_OK) |->
		(rsp_data.chunk_index == '0) && (rsp_data.chunk_offset == '0))
		else $error("error result carries a chunk");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
